>>> hw/rtl/kbl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kbl_pkg;

	localparam int MAX_NODES = 1024;
	localparam int MAX_KEYS  = 256;

	localparam int NODE_W  = $clog2(MAX_NODES) + 1;
	localparam int NADDR_W = $clog2(MAX_NODES);
	localparam int KADDR_W = $clog2(MAX_KEYS);
	localparam int KCNT_W  = $clog2(MAX_KEYS) + 1;
	localparam int KEY_W   = 64;
	localparam int OBJ_W   = 64;

	localparam logic [NODE_W-1:0] NODE_NONE = NODE_W'(MAX_NODES);
	localparam logic [KCNT_W-1:0] KEY_FULL  = KCNT_W'(MAX_KEYS);

	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_MOVE   = 3'd2;
	localparam logic [2:0] OP_WALK1  = 3'd3;
	localparam logic [2:0] OP_WALKN  = 3'd4;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_INACTIVE    = 3'd1;
	localparam logic [2:0] ST_WRONG_OBJ   = 3'd2;
	localparam logic [2:0] ST_KEY_MISSING = 3'd3;
	localparam logic [2:0] ST_POOL_FULL   = 3'd4;
	localparam logic [2:0] ST_TABLE_FULL  = 3'd5;
	localparam logic [2:0] ST_END         = 3'd6;
	localparam logic [2:0] ST_NO_NODE     = 3'd7;

	typedef struct packed {
		logic              go;
		logic [KEY_W-1:0]  key;
		logic [KCNT_W-1:0] count;
	} kbl_sreq_t;

	typedef struct packed {
		logic              done;
		logic              found;
		logic [KCNT_W-1:0] pos;
	} kbl_srch_t;

endpackage

`default_nettype wire

>>> hw/rtl/keyed_bucket_list_index.sv
`timescale 1ns / 1ps
`default_nettype none

// a key search is a binary search of at most 9 probes; a key insert or delete shifts the
// key table one moved entry at a time
// throughput: one transfer at a time, busy falls in the cycle the result strobe rises
// reset: a pass over all nodes rebuilds the free list and clears node active bits; no stall
module keyed_bucket_list_index (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [2:0]                    opcode,
	input  wire logic signed [kbl_pkg::OBJ_W-1:0] object_handle,
	input  wire logic signed [kbl_pkg::KEY_W-1:0] region_key,
	input  wire logic [kbl_pkg::NODE_W-1:0]    node_index,
	output logic                               done,
	output logic [2:0]                         status,
	output logic [kbl_pkg::NODE_W-1:0]         result_node,
	output logic signed [kbl_pkg::OBJ_W-1:0]   result_object
);
	import kbl_pkg::*;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE,
		S_ADD_SRCH, S_ADD_RD, S_ADD_WR,
		S_ATT_SRCH, S_ATT_HRD, S_ATT_HGET, S_INS_TEST, S_INS_WR, S_INS_PUT,
		S_ATT_LINK, S_ATT_LINK2,
		S_NRD, S_NCHK, S_MOV_OSRCH, S_MOV_NSRCH, S_DET_SRCH, S_DET,
		S_DEL_TEST, S_DEL_WR, S_POST,
		S_W1_SRCH, S_W1_HRD, S_W1_HGET, S_W2_RD, S_W2_OUT
	} state_t;

	// key table and bucket heads
	logic [KEY_W-1:0]  key_table [MAX_KEYS];
	logic [NODE_W-1:0] key_head  [MAX_KEYS];
	// node pool
	logic [OBJ_W-1:0]  node_object [MAX_NODES];
	logic [NODE_W-1:0] node_prev   [MAX_NODES];
	logic [NODE_W-1:0] node_next   [MAX_NODES];
	logic [KEY_W-1:0]  node_key    [MAX_NODES];
	logic              node_active [MAX_NODES];

	state_t            state_q;
	logic [NADDR_W-1:0] clr_q;
	logic [2:0]        op_q;
	logic [OBJ_W-1:0]  obj_q;
	logic [KEY_W-1:0]  key_q;
	logic [NODE_W-1:0] n_q;
	logic [KCNT_W-1:0] key_count_q;
	logic [NODE_W-1:0] free_head_q;
	logic [KCNT_W-1:0] pos_q;
	logic [KCNT_W-1:0] opos_q;
	logic              ofound_q;
	logic [KCNT_W-1:0] sh_q;
	logic [NODE_W-1:0] att_n_q;
	logic [KEY_W-1:0]  att_key_q;
	logic [NODE_W-1:0] att_head_q;
	logic [2:0]        att_st_q;
	logic [NODE_W-1:0] p_q;
	logic [NODE_W-1:0] x_q;
	kbl_sreq_t         sreq_q;
	kbl_srch_t         srsp;

	// registered read data
	logic [KEY_W-1:0]  ktab_rd;
	logic [NODE_W-1:0] khead_rd;
	logic [OBJ_W-1:0]  nobj_rd;
	logic [NODE_W-1:0] nprev_rd;
	logic [NODE_W-1:0] nnext_rd;
	logic [KEY_W-1:0]  nkey_rd;
	logic              nact_rd;

	// memory port controls
	logic               srch_rd_en;
	logic [KADDR_W-1:0] srch_rd_addr;
	logic [KADDR_W-1:0] fsm_kra;
	logic [KADDR_W-1:0] kra;
	logic               ktw_en, khw_en;
	logic [KADDR_W-1:0] kw_a;
	logic [KEY_W-1:0]   ktw_d;
	logic [NODE_W-1:0]  khw_d;
	logic [NADDR_W-1:0] nra;
	logic               npw_en, nnw_en, nkw_en, now_en, naw_en;
	logic [NADDR_W-1:0] npw_a, nnw_a, nkw_a, now_a, naw_a;
	logic [NODE_W-1:0]  npw_d, nnw_d;
	logic               naw_d;
	logic [KCNT_W-1:0]  sh_m1;
	logic [KCNT_W:0]    sh_p1;
	logic               sole;

	assign sh_m1 = sh_q - KCNT_W'(1);
	assign sh_p1 = {1'b0, sh_q} + (KCNT_W+1)'(1);
	assign sole  = (p_q >= NODE_NONE) && (x_q >= NODE_NONE);
	assign kra   = srch_rd_en ? srch_rd_addr : fsm_kra;
	assign busy  = (state_q != S_IDLE);

	kbl_search u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (sreq_q),
		.rd_data (ktab_rd),
		.rd_en   (srch_rd_en),
		.rd_addr (srch_rd_addr),
		.rsp     (srsp)
	);

	// port controls for the key and node memories, per sequencer step
	always_comb begin
		fsm_kra = '0;
		nra     = '0;
		ktw_en  = 1'b0;
		khw_en  = 1'b0;
		kw_a    = '0;
		ktw_d   = '0;
		khw_d   = '0;
		npw_en  = 1'b0; npw_a = '0; npw_d = '0;
		nnw_en  = 1'b0; nnw_a = '0; nnw_d = '0;
		nkw_en  = 1'b0; nkw_a = '0;
		now_en  = 1'b0; now_a = '0;
		naw_en  = 1'b0; naw_a = '0; naw_d = 1'b0;
		unique case (state_q)
			S_CLR: begin
				// free list runs downward from the top node
				nnw_en = 1'b1;
				nnw_a  = clr_q;
				nnw_d  = (clr_q == '0) ? NODE_NONE : {1'b0, clr_q} - NODE_W'(1);
				naw_en = 1'b1;
				naw_a  = clr_q;
			end
			S_NRD, S_W2_RD: nra = n_q[NADDR_W-1:0];
			S_ADD_RD:       nra = free_head_q[NADDR_W-1:0];
			S_ADD_WR: begin
				naw_en = 1'b1;
				naw_a  = free_head_q[NADDR_W-1:0];
				naw_d  = 1'b1;
				now_en = 1'b1;
				now_a  = free_head_q[NADDR_W-1:0];
			end
			S_ATT_HRD, S_W1_HRD: fsm_kra = pos_q[KADDR_W-1:0];
			S_INS_TEST: fsm_kra = sh_m1[KADDR_W-1:0];
			S_INS_WR, S_DEL_WR: begin
				ktw_en = 1'b1;
				khw_en = 1'b1;
				kw_a   = sh_q[KADDR_W-1:0];
				ktw_d  = ktab_rd;
				khw_d  = khead_rd;
			end
			S_INS_PUT: begin
				ktw_en = 1'b1;
				khw_en = 1'b1;
				kw_a   = pos_q[KADDR_W-1:0];
				ktw_d  = att_key_q;
				khw_d  = NODE_NONE;
			end
			S_ATT_LINK: begin
				npw_en = 1'b1;
				npw_a  = att_n_q[NADDR_W-1:0];
				npw_d  = NODE_NONE;
				nnw_en = 1'b1;
				nnw_a  = att_n_q[NADDR_W-1:0];
				nnw_d  = att_head_q;
				nkw_en = 1'b1;
				nkw_a  = att_n_q[NADDR_W-1:0];
				khw_en = 1'b1;
				kw_a   = pos_q[KADDR_W-1:0];
				khw_d  = att_n_q;
			end
			S_ATT_LINK2: begin
				npw_en = 1'b1;
				npw_a  = att_head_q[NADDR_W-1:0];
				npw_d  = att_n_q;
			end
			S_DET: begin
				if (ofound_q) begin
					if (x_q < NODE_NONE) begin
						npw_en = 1'b1;
						npw_a  = x_q[NADDR_W-1:0];
						npw_d  = p_q;
					end
					if (p_q < NODE_NONE) begin
						nnw_en = 1'b1;
						nnw_a  = p_q[NADDR_W-1:0];
						nnw_d  = x_q;
					end else begin
						khw_en = 1'b1;
						kw_a   = opos_q[KADDR_W-1:0];
						khw_d  = x_q;
					end
				end
			end
			S_DEL_TEST: fsm_kra = sh_p1[KADDR_W-1:0];
			S_POST: begin
				if (op_q == OP_REMOVE) begin
					naw_en = 1'b1;
					naw_a  = n_q[NADDR_W-1:0];
					nnw_en = 1'b1;
					nnw_a  = n_q[NADDR_W-1:0];
					nnw_d  = free_head_q;
				end
			end
			default: ;
		endcase
	end

	// key memories
	always_ff @(posedge clk) begin
		if (ktw_en) key_table[kw_a] <= ktw_d;
		if (khw_en) key_head[kw_a]  <= khw_d;
		ktab_rd  <= key_table[kra];
		khead_rd <= key_head[kra];
	end

	// node memories
	always_ff @(posedge clk) begin
		if (now_en) node_object[now_a] <= obj_q;
		if (npw_en) node_prev[npw_a]   <= npw_d;
		if (nnw_en) node_next[nnw_a]   <= nnw_d;
		if (nkw_en) node_key[nkw_a]    <= att_key_q;
		if (naw_en) node_active[naw_a] <= naw_d;
		nobj_rd  <= node_object[nra];
		nprev_rd <= node_prev[nra];
		nnext_rd <= node_next[nra];
		nkey_rd  <= node_key[nra];
		nact_rd  <= node_active[nra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			clr_q         <= '0;
			op_q          <= '0;
			obj_q         <= '0;
			key_q         <= '0;
			n_q           <= '0;
			key_count_q   <= '0;
			free_head_q   <= NODE_NONE - NODE_W'(1);
			pos_q         <= '0;
			opos_q        <= '0;
			ofound_q      <= 1'b0;
			sh_q          <= '0;
			att_n_q       <= '0;
			att_key_q     <= '0;
			att_head_q    <= '0;
			att_st_q      <= ST_OK;
			p_q           <= '0;
			x_q           <= '0;
			sreq_q        <= '0;
			done          <= 1'b0;
			status        <= ST_OK;
			result_node   <= NODE_NONE;
			result_object <= '0;
		end else begin
			done      <= 1'b0;
			sreq_q.go <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + NADDR_W'(1);
					if (clr_q == NADDR_W'(MAX_NODES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						op_q          <= opcode;
						obj_q         <= object_handle;
						key_q         <= region_key;
						n_q           <= node_index;
						result_node   <= NODE_NONE;
						result_object <= '0;
						unique case (opcode)
							OP_ADD: begin
								if (free_head_q >= NODE_NONE) begin
									status <= ST_POOL_FULL;
									done   <= 1'b1;
								end else begin
									sreq_q  <= '{go: 1'b1, key: region_key, count: key_count_q};
									state_q <= S_ADD_SRCH;
								end
							end
							OP_REMOVE, OP_MOVE: begin
								if (node_index >= NODE_NONE) begin
									status <= ST_NO_NODE;
									done   <= 1'b1;
								end else begin
									state_q <= S_NRD;
								end
							end
							OP_WALK1: begin
								sreq_q  <= '{go: 1'b1, key: region_key, count: key_count_q};
								state_q <= S_W1_SRCH;
							end
							OP_WALKN: begin
								if (node_index < NODE_NONE) begin
									state_q <= S_W2_RD;
								end else begin
									status <= (node_index == NODE_NONE) ? ST_END : ST_NO_NODE;
									done   <= 1'b1;
								end
							end
							default: begin
								status <= ST_END;
								done   <= 1'b1;
							end
						endcase
					end
				end
				// add: check room, then pop the free list
				S_ADD_SRCH: begin
					if (srsp.done) begin
						if (!srsp.found && key_count_q >= KEY_FULL) begin
							status  <= ST_TABLE_FULL;
							done    <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_ADD_RD;
						end
					end
				end
				S_ADD_RD: state_q <= S_ADD_WR;
				S_ADD_WR: begin
					free_head_q <= nnext_rd;
					att_n_q     <= free_head_q;
					att_key_q   <= key_q;
					att_st_q    <= ST_OK;
					sreq_q      <= '{go: 1'b1, key: key_q, count: key_count_q};
					state_q     <= S_ATT_SRCH;
				end
				// attach: find or insert key, push node at list head
				S_ATT_SRCH: begin
					if (srsp.done) begin
						pos_q <= srsp.pos;
						if (srsp.found) begin
							state_q <= S_ATT_HRD;
						end else begin
							sh_q    <= key_count_q;
							state_q <= S_INS_TEST;
						end
					end
				end
				S_ATT_HRD: state_q <= S_ATT_HGET;
				S_ATT_HGET: begin
					att_head_q <= khead_rd;
					state_q    <= S_ATT_LINK;
				end
				S_INS_TEST: state_q <= (sh_q > pos_q) ? S_INS_WR : S_INS_PUT;
				S_INS_WR: begin
					sh_q    <= sh_m1;
					state_q <= S_INS_TEST;
				end
				S_INS_PUT: begin
					key_count_q <= key_count_q + KCNT_W'(1);
					att_head_q  <= NODE_NONE;
					state_q     <= S_ATT_LINK;
				end
				S_ATT_LINK: begin
					if (att_head_q < NODE_NONE) begin
						state_q <= S_ATT_LINK2;
					end else begin
						status      <= att_st_q;
						result_node <= (op_q == OP_ADD) ? att_n_q : NODE_NONE;
						done        <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_ATT_LINK2: begin
					status      <= att_st_q;
					result_node <= (op_q == OP_ADD) ? att_n_q : NODE_NONE;
					done        <= 1'b1;
					state_q     <= S_IDLE;
				end
				// remove and move: node checks
				S_NRD: state_q <= S_NCHK;
				S_NCHK: begin
					p_q <= nprev_rd;
					x_q <= nnext_rd;
					if (!nact_rd) begin
						status  <= ST_INACTIVE;
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else if (nobj_rd != obj_q) begin
						status  <= ST_WRONG_OBJ;
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else if (op_q == OP_REMOVE) begin
						sreq_q  <= '{go: 1'b1, key: nkey_rd, count: key_count_q};
						state_q <= S_DET_SRCH;
					end else if (nkey_rd == key_q) begin
						status  <= ST_OK;
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						sreq_q  <= '{go: 1'b1, key: nkey_rd, count: key_count_q};
						state_q <= S_MOV_OSRCH;
					end
				end
				S_MOV_OSRCH: begin
					if (srsp.done) begin
						ofound_q <= srsp.found;
						opos_q   <= srsp.pos;
						sreq_q   <= '{go: 1'b1, key: key_q, count: key_count_q};
						state_q  <= S_MOV_NSRCH;
					end
				end
				S_MOV_NSRCH: begin
					if (srsp.done) begin
						// a full table is fine when the move empties the old key
						if (!srsp.found && key_count_q >= KEY_FULL && !(ofound_q && sole)) begin
							status  <= ST_TABLE_FULL;
							done    <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_DET;
						end
					end
				end
				S_DET_SRCH: begin
					if (srsp.done) begin
						ofound_q <= srsp.found;
						opos_q   <= srsp.pos;
						state_q  <= S_DET;
					end
				end
				S_DET: begin
					if (ofound_q && sole) begin
						sh_q    <= opos_q;
						state_q <= S_DEL_TEST;
					end else begin
						state_q <= S_POST;
					end
				end
				// emptied key: shift the table down over it
				S_DEL_TEST: begin
					if (sh_p1 < {1'b0, key_count_q}) begin
						state_q <= S_DEL_WR;
					end else begin
						key_count_q <= key_count_q - KCNT_W'(1);
						state_q     <= S_POST;
					end
				end
				S_DEL_WR: begin
					sh_q    <= sh_p1[KCNT_W-1:0];
					state_q <= S_DEL_TEST;
				end
				S_POST: begin
					if (op_q == OP_REMOVE) begin
						free_head_q <= n_q;
						status      <= ofound_q ? ST_OK : ST_KEY_MISSING;
						done        <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						att_st_q  <= ofound_q ? ST_OK : ST_KEY_MISSING;
						att_n_q   <= n_q;
						att_key_q <= key_q;
						sreq_q    <= '{go: 1'b1, key: key_q, count: key_count_q};
						state_q   <= S_ATT_SRCH;
					end
				end
				// walks
				S_W1_SRCH: begin
					if (srsp.done) begin
						pos_q <= srsp.pos;
						if (srsp.found) begin
							state_q <= S_W1_HRD;
						end else begin
							status  <= ST_END;
							done    <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_W1_HRD: state_q <= S_W1_HGET;
				S_W1_HGET: begin
					if (khead_rd < NODE_NONE) begin
						n_q     <= khead_rd;
						state_q <= S_W2_RD;
					end else begin
						status  <= ST_END;
						done    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_W2_RD: state_q <= S_W2_OUT;
				S_W2_OUT: begin
					status        <= ST_OK;
					result_object <= nobj_rd;
					result_node   <= nnext_rd;
					done          <= 1'b1;
					state_q       <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result strobe only when back in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// an accepted transfer either finishes at once or holds busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transfer dropped");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= KEY_FULL)
		else $error("key count beyond table size");

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= NODE_NONE)
		else $error("free list head out of range");

	// the table only shrinks when a key empties
	a_count_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(key_count_q < $past(key_count_q)) |-> ($past(state_q) == S_DEL_TEST))
		else $error("key count dropped outside delete");

endmodule

`default_nettype wire

>>> hw/rtl/kbl_search.sv
`timescale 1ns / 1ps
`default_nettype none

module kbl_search (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire kbl_pkg::kbl_sreq_t         req,
	input  wire logic [kbl_pkg::KEY_W-1:0]  rd_data,
	output logic                            rd_en,
	output logic [kbl_pkg::KADDR_W-1:0]     rd_addr,
	output kbl_pkg::kbl_srch_t              rsp
);
	import kbl_pkg::*;

	typedef enum logic [1:0] {SR_IDLE, SR_TEST, SR_CMP} sr_state_t;

	sr_state_t         state_q;
	logic [KCNT_W-1:0] lo_q;
	logic [KCNT_W-1:0] hi_q;
	logic [KEY_W-1:0]  key_q;
	logic [KCNT_W:0]   mid_sum;
	logic [KADDR_W-1:0] mid;

	// probe at (lo + hi_incl) / 2, hi kept exclusive
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (KCNT_W+1)'(1);
	assign mid     = mid_sum[KADDR_W:1];
	assign rd_en   = (state_q == SR_TEST);
	assign rd_addr = mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SR_IDLE;
			lo_q      <= '0;
			hi_q      <= '0;
			key_q     <= '0;
			rsp       <= '0;
		end else begin
			rsp.done <= 1'b0;
			unique case (state_q)
				SR_IDLE: begin
					if (req.go) begin
						lo_q    <= '0;
						hi_q    <= req.count;
						key_q   <= req.key;
						state_q <= SR_TEST;
					end
				end
				SR_TEST: begin
					if (lo_q < hi_q) begin
						state_q <= SR_CMP;
					end else begin
						rsp.done  <= 1'b1;
						rsp.found <= 1'b0;
						rsp.pos   <= lo_q;
						state_q   <= SR_IDLE;
					end
				end
				SR_CMP: begin
					if (rd_data == key_q) begin
						rsp.done  <= 1'b1;
						rsp.found <= 1'b1;
						rsp.pos   <= {1'b0, mid};
						state_q   <= SR_IDLE;
					end else if ($signed(rd_data) < $signed(key_q)) begin
						lo_q    <= {1'b0, mid} + KCNT_W'(1);
						state_q <= SR_TEST;
					end else begin
						hi_q    <= {1'b0, mid};
						state_q <= SR_TEST;
					end
				end
				default: state_q <= SR_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import kbl_pkg::*;

	localparam int CYCLE_LIMIT = 6000000;

	typedef struct {
		logic [2:0]         op;
		logic signed [63:0] obj;
		logic signed [63:0] key;
		logic [10:0]        node;
	} request_t;

	typedef struct {
		logic [2:0]         st;
		logic [10:0]        node;
		logic signed [63:0] obj;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] opcode = OP_ADD;
	logic signed [63:0] object_handle = '0;
	logic signed [63:0] region_key = '0;
	logic [10:0] node_index = '0;
	logic busy, done;
	logic [2:0] status;
	logic [10:0] result_node;
	logic signed [63:0] result_object;

	keyed_bucket_list_index dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .object_handle(object_handle), .region_key(region_key),
		.node_index(node_index), .done(done), .status(status),
		.result_node(result_node), .result_object(result_object)
	);

	always #6 clk = ~clk;

	// shadow copy of the index: sorted key table, bucket lists, free pool
	logic signed [63:0] sh_keys[MAX_KEYS];
	logic [10:0]        sh_khead[MAX_KEYS];
	int                 sh_kcount;
	logic signed [63:0] sh_nobj[MAX_NODES];
	logic signed [63:0] sh_nkey[MAX_NODES];
	logic [10:0]        sh_nprev[MAX_NODES];
	logic [10:0]        sh_nnext[MAX_NODES];
	bit                 sh_nact[MAX_NODES];
	bit                 sh_nwritten[MAX_NODES];
	logic [10:0]        sh_free;
	logic [10:0]        walk_iter = NODE_NONE;

	request_t request_q[$];
	answer_t  answer_q[$];
	int  in_flight = 0;
	int  errors = 0;
	int  cycles = 0;
	bit  taken = 1'b0;
	int  gap_left = 0;
	int  burst_left = 4;
	logic signed [63:0] key_pool[40];

	// binary search over the signed key table; pos is the insert point on a miss
	function automatic bit key_lookup(input logic signed [63:0] k, output int pos);
		int lo, hi, mid;
		lo = 0;
		hi = sh_kcount - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (sh_keys[mid] == k) begin
				pos = mid;
				return 1'b1;
			end
			if (sh_keys[mid] < k) lo = mid + 1;
			else hi = mid - 1;
		end
		pos = lo;
		return 1'b0;
	endfunction

	function automatic void bucket_push(input int n, input logic signed [63:0] k);
		int pos;
		if (!key_lookup(k, pos)) begin
			for (int i = sh_kcount; i > pos; i--) begin
				sh_keys[i]  = sh_keys[i-1];
				sh_khead[i] = sh_khead[i-1];
			end
			sh_keys[pos]  = k;
			sh_khead[pos] = NODE_NONE;
			sh_kcount++;
		end
		sh_nprev[n] = NODE_NONE;
		sh_nnext[n] = sh_khead[pos];
		if (sh_khead[pos] < NODE_NONE) sh_nprev[sh_khead[pos]] = 11'(n);
		sh_khead[pos] = 11'(n);
		sh_nkey[n] = k;
	endfunction

	// unlink a node; an emptied key leaves the table
	function automatic bit bucket_unlink(input int n);
		int pos;
		logic [10:0] p, x;
		p = sh_nprev[n];
		x = sh_nnext[n];
		if (!key_lookup(sh_nkey[n], pos)) return 1'b0;
		if (x < NODE_NONE) sh_nprev[x] = p;
		if (p < NODE_NONE) begin
			sh_nnext[p] = x;
		end else begin
			sh_khead[pos] = x;
			if (x >= NODE_NONE) begin
				for (int i = pos; i < sh_kcount - 1; i++) begin
					sh_keys[i]  = sh_keys[i+1];
					sh_khead[i] = sh_khead[i+1];
				end
				sh_kcount--;
			end
		end
		return 1'b1;
	endfunction

	// applies one transfer to the shadow index and returns the answer it should give
	function automatic answer_t index_apply(input request_t r);
		answer_t a;
		int pos, opos, n, fnode;
		bit sole, frees;
		a.st = ST_END;
		a.node = NODE_NONE;
		a.obj = '0;
		n = r.node;
		case (r.op)
			OP_ADD: begin
				if (sh_free >= NODE_NONE) begin
					a.st = ST_POOL_FULL;
				end else if (!key_lookup(r.key, pos) && sh_kcount >= MAX_KEYS) begin
					a.st = ST_TABLE_FULL;
				end else begin
					fnode = sh_free;
					sh_free = sh_nnext[fnode];
					sh_nact[fnode] = 1'b1;
					sh_nwritten[fnode] = 1'b1;
					sh_nobj[fnode] = r.obj;
					bucket_push(fnode, r.key);
					a.st = ST_OK;
					a.node = 11'(fnode);
				end
			end
			OP_REMOVE, OP_MOVE: begin
				if (n >= MAX_NODES) a.st = ST_NO_NODE;
				else if (!sh_nact[n]) a.st = ST_INACTIVE;
				else if (sh_nobj[n] != r.obj) a.st = ST_WRONG_OBJ;
				else if (r.op == OP_REMOVE) begin
					a.st = bucket_unlink(n) ? ST_OK : ST_KEY_MISSING;
					sh_nact[n] = 1'b0;
					sh_nnext[n] = sh_free;
					sh_free = 11'(n);
				end else if (sh_nkey[n] == r.key) begin
					a.st = ST_OK;
				end else begin
					sole = sh_nprev[n] >= NODE_NONE && sh_nnext[n] >= NODE_NONE;
					frees = key_lookup(sh_nkey[n], opos) && sole;
					if (!key_lookup(r.key, pos) && sh_kcount >= MAX_KEYS && !frees) begin
						a.st = ST_TABLE_FULL;
					end else begin
						a.st = bucket_unlink(n) ? ST_OK : ST_KEY_MISSING;
						bucket_push(n, r.key);
					end
				end
			end
			OP_WALK1: begin
				if (key_lookup(r.key, pos) && sh_khead[pos] < NODE_NONE) begin
					a.st = ST_OK;
					a.obj = sh_nobj[sh_khead[pos]];
					a.node = sh_nnext[sh_khead[pos]];
				end
			end
			OP_WALKN: begin
				if (n < MAX_NODES) begin
					a.st = ST_OK;
					a.obj = sh_nobj[n];
					a.node = sh_nnext[n];
				end else if (n > MAX_NODES) begin
					a.st = ST_NO_NODE;
				end
			end
			default: ;
		endcase
		if (r.op == OP_WALK1 || r.op == OP_WALKN) walk_iter = a.node;
		return a;
	endfunction

	// monitor: checks result strobes, predicts each accepted transfer
	always @(posedge clk) begin
		answer_t want;
		request_t got;
		cycles <= cycles + 1;
		if (done) begin
			if (answer_q.size() == 0) begin
				$display("%0t: result with nothing expected: status %0d node %0d obj %h",
					$time, status, result_node, result_object);
				errors++;
			end else begin
				want = answer_q.pop_front();
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					errors++;
				end
				if (result_node !== want.node) begin
					$display("%0t: result_node expected %0d actual %0d",
						$time, want.node, result_node);
					errors++;
				end
				if (result_object !== want.obj) begin
					$display("%0t: result_object expected %h actual %h",
						$time, want.obj, result_object);
					errors++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			got.op = opcode;
			got.obj = object_handle;
			got.key = region_key;
			got.node = node_index;
			answer_q.push_back(index_apply(got));
			in_flight--;
			taken <= 1'b1;
		end
	end

	// driver: bursts of transfers with random gaps in between
	always @(negedge clk) begin
		request_t r;
		bit next_start;
		next_start = start;
		if (start && taken) next_start = 1'b0;
		if (!next_start && arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (request_q.size() != 0) begin
				r = request_q.pop_front();
				opcode <= r.op;
				object_handle <= r.obj;
				region_key <= r.key;
				node_index <= r.node;
				next_start = 1'b1;
				if (--burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
				end
			end
		end
		taken <= 1'b0;
		start <= next_start;
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic signed [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic signed [63:0] pick_key();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return key_pool[$urandom_range(0, 39)];
		if (r < 8 && sh_kcount > 0) return sh_keys[$urandom_range(0, sh_kcount - 1)];
		return rand64();
	endfunction

	// a node that is mostly live, so remove and move get past the checks
	function automatic int pick_node();
		int n;
		for (int t = 0; t < 12; t++) begin
			n = $urandom_range(0, MAX_NODES - 1);
			if (sh_nact[n]) return n;
		end
		return n;
	endfunction

	// object for a given node: usually the owner, sometimes a stranger
	function automatic logic signed [63:0] owner_of(input int n);
		if (n < MAX_NODES && sh_nwritten[n] && $urandom_range(0, 9) != 0) return sh_nobj[n];
		return rand64();
	endfunction

	function automatic request_t random_request(input bit fill, input bit fresh_keys);
		request_t r;
		int w, n;
		r.op = OP_ADD;
		r.obj = rand64();
		r.key = fresh_keys ? rand64() : pick_key();
		r.node = NODE_NONE;
		if (fill) return r;
		w = $urandom_range(0, 99);
		if (w < 25) begin
			r.op = OP_ADD;
		end else if (w < 50 || w < 70) begin
			r.op = (w < 50) ? OP_REMOVE : OP_MOVE;
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_NODES, 2047) : pick_node();
			r.node = 11'(n);
			r.obj = owner_of(n);
			if (r.op == OP_MOVE && n < MAX_NODES && sh_nwritten[n] && $urandom_range(0, 7) == 0)
				r.key = sh_nkey[n];
		end else if (w < 80) begin
			r.op = OP_WALK1;
		end else if (w < 95) begin
			r.op = OP_WALKN;
			// follow a live walk, else jump to a node that has an object, to the end or out of range
			if (walk_iter < NODE_NONE && sh_nwritten[walk_iter] && $urandom_range(0, 9) < 8) begin
				r.node = walk_iter;
			end else begin
				n = $urandom_range(0, 9);
				if (n == 0) r.node = NODE_NONE;
				else if (n == 1) r.node = 11'($urandom_range(MAX_NODES + 1, 2047));
				else begin
					r.node = NODE_NONE;
					for (int t = 0; t < 20; t++) begin
						n = $urandom_range(0, MAX_NODES - 1);
						if (sh_nwritten[n]) begin
							r.node = 11'(n);
							break;
						end
					end
				end
			end
		end else begin
			r.op = 3'($urandom_range(5, 7));
			r.node = 11'($urandom);
		end
		return r;
	endfunction

	// stimulus is made one transfer at a time so it can steer by the shadow state
	task automatic settle();
		while (in_flight != 0) @(posedge clk);
		#1;
	endtask

	task automatic issue(input request_t r);
		settle();
		request_q.push_back(r);
		in_flight++;
	endtask

	function automatic request_t make_req(input logic [2:0] op, input logic signed [63:0] obj,
			input logic signed [63:0] key, input logic [10:0] node);
		request_t r;
		r.op = op;
		r.obj = obj;
		r.key = key;
		r.node = node;
		return r;
	endfunction

	localparam logic signed [63:0] KMIN = 64'sh8000000000000000;
	localparam logic signed [63:0] KMAX = 64'sh7fffffffffffffff;
	localparam logic signed [63:0] OBJ_A = 64'sh8000000000000001;
	localparam logic signed [63:0] OBJ_B = 64'sh7ffffffffffffffe;

	initial begin
		for (int i = 0; i < MAX_NODES; i++) begin
			sh_nnext[i] = (i == 0) ? NODE_NONE : 11'(i - 1);
			sh_nact[i] = 1'b0;
			sh_nwritten[i] = 1'b0;
		end
		sh_kcount = 0;
		sh_free = NODE_NONE - 1;
		for (int i = 0; i < 40; i++) key_pool[i] = rand64();
		key_pool[0] = KMIN;
		key_pool[1] = KMAX;
		key_pool[2] = 0;
		key_pool[3] = -1;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// directed: extreme keys and objects, every opcode, inactive, wrong-object, no-node and end answers
		issue(make_req(OP_ADD, OBJ_A, KMIN, NODE_NONE));
		issue(make_req(OP_ADD, OBJ_B, KMAX, NODE_NONE));
		issue(make_req(OP_ADD, 64'sd0, 64'sd0, NODE_NONE));
		issue(make_req(OP_ADD, 64'sd2, KMIN, NODE_NONE));
		issue(make_req(OP_WALK1, 0, KMIN, NODE_NONE));
		settle();
		issue(make_req(OP_WALKN, 0, 0, walk_iter));
		settle();
		issue(make_req(OP_WALKN, 0, 0, walk_iter));
		issue(make_req(OP_WALK1, 0, 64'sd5, NODE_NONE));
		issue(make_req(OP_WALKN, 0, 0, 11'd1025));
		issue(make_req(OP_WALKN, 0, 0, 11'd2047));
		issue(make_req(OP_REMOVE, OBJ_A, 0, NODE_NONE));
		issue(make_req(OP_MOVE, OBJ_A, 0, 11'd2047));
		issue(make_req(OP_REMOVE, OBJ_A, 0, 11'd3));
		issue(make_req(OP_REMOVE, OBJ_B, 0, 11'd1023));
		issue(make_req(OP_MOVE, OBJ_B, KMAX, 11'd1022));
		issue(make_req(OP_MOVE, OBJ_B, -64'sd1, 11'd1022));
		issue(make_req(OP_MOVE, OBJ_A, KMAX, 11'd1023));
		issue(make_req(OP_REMOVE, 64'sd0, 0, 11'd1021));
		issue(make_req(OP_REMOVE, 64'sd0, 0, 11'd1021));
		issue(make_req(3'd5, OBJ_A, KMIN, 11'd0));
		issue(make_req(3'd6, OBJ_A, KMIN, 11'd0));
		issue(make_req(3'd7, 64'sd0, KMAX, 11'd2047));

		// fill the key table past its limit
		for (int i = 0; i < 270; i++) begin
			settle();
			issue(random_request(1'b1, 1'b1));
		end

		// mixed traffic over a full table as it drains and refills
		for (int i = 0; i < 455; i++) begin
			settle();
			issue(random_request(1'b0, 1'b0));
		end

		while (in_flight != 0 || answer_q.size() != 0 || start) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/kbl_pkg.sv
hw/rtl/kbl_search.sv
hw/rtl/keyed_bucket_list_index.sv
bench/testbench.sv
